// ----- sv/utf16le_to_utf8_transcoder_assert.svh -----
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef UTF16LE_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_ASSERT_SVH

// same-cycle implication
`define U16U8_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u16u8 assertion failed");

// next-cycle implication
`define U16U8_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u16u8 assertion failed");

`endif

// ----- sv/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and utf-8 encoding helpers
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [15:0] HI_SUR_LO = 16'hD800;
	localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SUR_LO = 16'hDC00;
	localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// one queued job: an optional flushed high surrogate, then an optional code point
	typedef struct packed {
		logic        has_flush;
		logic [9:0]  flush_bits;
		logic        has_pt;
		logic [20:0] cp;
	} job_t;

	typedef enum logic {
		PH_FLUSH,
		PH_POINT
	} back_phase_t;

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] len;
		if (cp < 21'h80) begin
			len = 3'd1;
		end else if (cp < 21'h800) begin
			len = 3'd2;
		end else if (cp < 21'h10000) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
			input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (len)
			3'd1: b = cp[7:0];
			3'd2: begin
				unique case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd3: begin
				unique case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				unique case (idx)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					2'd3: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- sv/utf16le_to_utf8_transcoder.sv -----
// latency: the first byte of a word passes through the queue and then the back end's output register
// throughput: one byte per cycle from the back end while out_stall is low, up to 6 bytes per word
// a word that yields no bytes queues no job; the front stalls when the 4-job queue fills
// reset: arst_n asynchronous active low clears surrogate, count, limit and queue state
// reset: max_units returns to 32768
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// utf-16 code units in, utf-8 bytes out, decoupled front and back
// ----------------------------------------------------------------------------
`default_nettype none

module utf16le_to_utf8_transcoder import u16u8_pkg::*; #(
	parameter int UNIT_LIMIT = 32768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] code_unit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last_of_run
);

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	u16u8_front #(
		.UNIT_LIMIT(UNIT_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.code_unit(code_unit),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	u16u8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

`default_nettype wire

// ----- sv/u16u8_front.sv -----
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, tracks surrogate and limit state, queues encode jobs
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front import u16u8_pkg::*; #(
	parameter int UNIT_LIMIT = 32768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        q_full,
	output logic             push,
	output job_t             push_job
);

	localparam logic [16:0] LIMIT = 17'(UNIT_LIMIT);

	logic [15:0] max_units_q;
	logic [9:0]  held_bits_q;
	logic        held_q;
	logic [15:0] units_q;
	logic        past_q;

	logic [9:0]  held_bits_d;
	logic        held_d;
	logic [15:0] units_d;
	logic        past_d;

	logic [16:0] limit;
	logic [16:0] units_inc;
	logic        fire;
	logic        is_high;
	logic        is_low;

	assign in_stall  = q_full;
	assign fire      = in_valid && !in_stall;
	assign limit     = ({1'b0, max_units_q} < LIMIT) ? {1'b0, max_units_q} : LIMIT;
	assign units_inc = {1'b0, units_q} + 17'd1;
	assign is_high   = (code_unit >= HI_SUR_LO) && (code_unit <= HI_SUR_HI);
	assign is_low    = (code_unit >= LO_SUR_LO) && (code_unit <= LO_SUR_HI);

	always_comb begin
		held_bits_d = held_bits_q;
		held_d      = held_q;
		units_d     = units_q;
		past_d      = past_q;
		push_job    = '0;
		priority if (code_unit == 16'h0000) begin
			push_job.has_flush  = held_q;
			push_job.flush_bits = held_bits_q;
			held_d              = 1'b0;
			held_bits_d         = '0;
			units_d             = '0;
			past_d              = 1'b0;
		end else if (past_q || ({1'b0, units_q} >= limit)) begin
			past_d = 1'b1;
		end else begin
			units_d = units_inc[15:0];
			if (held_q && is_low) begin
				push_job.has_pt = 1'b1;
				push_job.cp     = {1'b0, held_bits_q, code_unit[9:0]} + SUPP_BASE;
				held_d          = 1'b0;
				held_bits_d     = '0;
			end else begin
				push_job.has_flush  = held_q;
				push_job.flush_bits = held_bits_q;
				held_d              = 1'b0;
				held_bits_d         = '0;
				if (is_high && (units_inc < limit)) begin
					held_d      = 1'b1;
					held_bits_d = code_unit[9:0];
				end else begin
					push_job.has_pt = 1'b1;
					push_job.cp     = {5'b00000, code_unit};
				end
			end
		end
	end

	assign push = fire && (push_job.has_flush || push_job.has_pt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= 16'h8000;
			held_bits_q <= '0;
			held_q      <= 1'b0;
			units_q     <= '0;
			past_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_units_q <= cfg_wdata;
			end
			if (fire) begin
				held_bits_q <= held_bits_d;
				held_q      <= held_d;
				units_q     <= units_d;
				past_q      <= past_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/u16u8_queue.sv -----
// ----------------------------------------------------------------------------
// u16u8_queue
// short job fifo between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue import u16u8_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full       = (count_q == (Q_AW + 1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/u16u8_back.sv -----
// ----------------------------------------------------------------------------
// u16u8_back
// walks queued jobs one utf-8 byte per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back import u16u8_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire job_t head_job,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] out_byte,
	output logic      last_of_run
);

	back_phase_t phase_q;
	back_phase_t phase_d;
	logic [1:0]  idx_q;
	logic [1:0]  idx_d;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;

	logic        in_point;
	logic [20:0] cur_cp;
	logic [2:0]  cur_len;
	logic [7:0]  cur_byte;
	logic        pt_end;
	logic        job_end;
	logic        emit;

	assign in_point = (phase_q == PH_POINT) || !head_job.has_flush;
	assign cur_cp   = in_point ? head_job.cp : {5'b00000, 6'b110110, head_job.flush_bits};
	assign cur_len  = utf8_len(cur_cp);
	assign cur_byte = utf8_byte(cur_cp, cur_len, idx_q);
	assign pt_end   = ({1'b0, idx_q} == (cur_len - 3'd1));
	assign job_end  = pt_end && (in_point || !head_job.has_pt);
	assign emit     = head_valid && (!out_valid_q || !out_stall);
	assign pop      = emit && job_end;

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		if (emit) begin
			priority if (job_end) begin
				phase_d = PH_FLUSH;
				idx_d   = 2'd0;
			end else if (pt_end) begin
				phase_d = PH_POINT;
				idx_d   = 2'd0;
			end else begin
				idx_d = idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLUSH;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_byte;
			last_q     <= job_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

// ----- sv/u16u8_checker.sv -----
// ----------------------------------------------------------------------------
// u16u8_checker
// port-level checks on the output byte stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf16le_to_utf8_transcoder_assert.svh"

module u16u8_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        last_of_run
);

	// an ascii byte is always the final byte of its word
	`U16U8_ASSERT_IMP(a_ascii_last, out_valid && !out_byte[7], last_of_run)

	// a lead byte of a multi-byte sequence never ends a word
	`U16U8_ASSERT_IMP(a_lead_not_last, out_valid && (out_byte[7:6] == 2'b11), !last_of_run)

	`U16U8_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

	`U16U8_ASSERT_NXT(a_out_stable, out_valid && out_stall,
		$stable(out_byte) && $stable(last_of_run))

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_chk (.*);

`default_nettype wire

// ----- test/utf8_stream_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_checker
// watches the code unit and byte channels of the transcoder, predicts the
// utf-8 bytes of every accepted word and compares them in order
// ----------------------------------------------------------------------------
module utf8_stream_checker import u16u8_pkg::*; #(
	parameter int UNIT_LIMIT = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic        last_of_run,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} utf8_byte_t;

	utf8_byte_t expected_bytes[$];
	logic [7:0] step_bytes[$];

	logic [15:0] max_units;
	logic [9:0]  held_bits;
	logic        held;
	logic [15:0] units_taken;
	logic        past_limit;

	task automatic emit_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			step_bytes.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			step_bytes.push_back({3'b110, cp[10:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < SUPP_BASE) begin
			step_bytes.push_back({4'b1110, cp[15:12]});
			step_bytes.push_back({2'b10, cp[11:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			step_bytes.push_back({5'b11110, cp[20:18]});
			step_bytes.push_back({2'b10, cp[17:12]});
			step_bytes.push_back({2'b10, cp[11:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end
	endtask

	task automatic flush_held();
		if (held) begin
			emit_point({5'd0, 6'b110110, held_bits});
			held = 1'b0;
			held_bits = '0;
		end
	endtask

	task automatic transcode_unit(input logic [15:0] u);
		int         lim;
		logic       done;
		utf8_byte_t b;
		step_bytes.delete();
		lim = (int'(max_units) < UNIT_LIMIT) ? int'(max_units) : UNIT_LIMIT;
		if (u == 16'd0) begin
			flush_held();
			units_taken = '0;
			past_limit = 1'b0;
		end else if (past_limit || int'(units_taken) >= lim) begin
			past_limit = 1'b1;
		end else begin
			done = 1'b0;
			units_taken = units_taken + 16'd1;
			if (held) begin
				if (u >= LO_SUR_LO && u <= LO_SUR_HI) begin
					emit_point(SUPP_BASE + {1'b0, held_bits, u[9:0]});
					held = 1'b0;
					held_bits = '0;
					done = 1'b1;
				end else begin
					flush_held();
				end
			end
			if (!done) begin
				if (u >= HI_SUR_LO && u <= HI_SUR_HI && int'(units_taken) < lim) begin
					held_bits = u[9:0];
					held = 1'b1;
				end else begin
					emit_point({5'd0, u});
				end
			end
		end
		foreach (step_bytes[i]) begin
			b.value = step_bytes[i];
			b.last = (i == step_bytes.size() - 1);
			expected_bytes.push_back(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		utf8_byte_t want;
		if (!arst_n) begin
			max_units = 16'd32768;
			held_bits = '0;
			held = 1'b0;
			units_taken = '0;
			past_limit = 1'b0;
			expected_bytes.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				max_units = cfg_wdata;
			end
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: byte with nothing expected: expected none, actual %h last %b",
						$time, out_byte, last_of_run);
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value) begin
						mismatches++;
						$display("%0t: out_byte mismatch: expected %h, actual %h",
							$time, want.value, out_byte);
					end
					if (last_of_run !== want.last) begin
						mismatches++;
						$display("%0t: last_of_run mismatch: expected %b, actual %b",
							$time, want.last, last_of_run);
					end
				end
			end
			if (in_valid && !in_stall) begin
				transcode_unit(code_unit);
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// ----- test/tb_utf16le_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// tb_utf16le_to_utf8_transcoder
// drives directed and random utf-16 strings through the transcoder under
// several unit limits, with random gaps and stalls on both channels, and
// gives the verdict from the stream checker
// ----------------------------------------------------------------------------
module tb_utf16le_to_utf8_transcoder;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 120;
	localparam int SETTLE_CYCLES  = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] code_unit = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;

	int   mismatches;
	int   pending_bytes;
	int   units_sent = 0;
	int   idle_cycles = 0;
	int   stall_gap;
	logic no_idle = 1'b0;
	logic long_hold = 1'b0;
	logic hold_done = 1'b0;

	utf16le_to_utf8_transcoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	utf8_stream_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.mismatches  (mismatches),
		.pending     (pending_bytes)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// byte sink: random stall before each byte, plus one long hold on request
	always begin
		@(negedge clk);
		if (long_hold && !hold_done) begin
			out_stall = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_done = 1'b1;
		end
		stall_gap = no_idle ? 0 : $urandom_range(0, 3);
		if (stall_gap != 0) begin
			out_stall = 1'b1;
			repeat (stall_gap) @(negedge clk);
		end
		out_stall = 1'b0;
		do @(posedge clk); while (!out_valid && !(long_hold && !hold_done));
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_unit(input logic [15:0] u);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		code_unit = u;
		do @(posedge clk); while (in_stall);
		units_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_bytes != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_units(input logic [15:0] value);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// a string of random units of mixed kinds, closed by a zero word
	task automatic send_text(input int n);
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: send_unit(16'($urandom_range(16'h0001, 16'h007F)));
				3:       send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
				4: begin
					if ($urandom_range(0, 1)) begin
						send_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
					end else begin
						send_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
					end
				end
				5, 6: begin
					send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
					send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				7:       send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
				8:       send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
				default: send_unit(16'($urandom_range(0, 16'hFFFF)));
			endcase
		end
		send_unit(16'h0000);
	endtask

	task automatic run_phase(input logic [15:0] limit_value, input int quota);
		int start;
		write_max_units(limit_value);
		start = units_sent;
		while (units_sent - start < quota) send_text($urandom_range(1, 10));
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// encoding length boundaries and surrogate handling
		send_unit(16'h0001);
		send_unit(16'h007F);
		send_unit(16'h0080);
		send_unit(16'h07FF);
		send_unit(16'h0800);
		send_unit(16'hFFFF);
		send_unit(16'hD800);
		send_unit(16'hDC00);
		send_unit(16'hDBFF);
		send_unit(16'hDFFF);
		send_unit(16'hD812);
		send_unit(16'h0041);
		send_unit(16'hD801);
		send_unit(16'hD802);
		send_unit(16'h0000);
		send_unit(16'hDE00);
		send_unit(16'h0000);

		// high surrogate as last allowed unit, then units past the limit
		write_max_units(16'd1);
		send_unit(16'hD800);
		send_unit(16'h0041);
		send_unit(16'h0000);

		// zero limit ignores everything
		write_max_units(16'd0);
		send_unit(16'h0041);
		send_unit(16'h0000);

		// limit lowered while a high surrogate is held
		write_max_units(16'hFFFF);
		send_unit(16'hD900);
		write_max_units(16'd1);
		send_unit(16'h0041);
		send_unit(16'h0000);

		run_phase(16'd32768, 40);
		long_hold = 1'b1;
		no_idle = 1'b1;
		repeat (4) send_text(8);
		no_idle = 1'b0;
		wait_drained();
		run_phase(16'd32768, 40);
		run_phase(16'd3, 50);
		no_idle = 1'b1;
		run_phase(16'hFFFF, 30);
		no_idle = 1'b0;
		run_phase(16'd1, 30);
		run_phase(16'd5, 30);
		run_phase(16'd0, 15);
		run_phase(16'd2, 30);
		run_phase(16'd32768, 40);

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_bytes == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
